// File: design/xsp_pkg.sv
// Shared types and constants for the sound stream parser.
`timescale 1ns / 1ps
package xsp_pkg;
    localparam int unsigned MaxFileBytes = 33554432;
    localparam int unsigned MaxNameBytes = 4096;

    typedef enum logic [1:0] {
        K_FORMAT  = 2'd0,
        K_WAVE    = 2'd1,
        K_SUMMARY = 2'd2
    } t_kind;

    typedef enum logic [3:0] {
        E_OK = 4'd0, E_SIZE = 4'd1, E_MAGIC = 4'd2, E_COMPRESSED = 4'd3,
        E_DECLARED = 4'd4, E_RCOUNT = 4'd5, E_RNAME = 4'd6, E_RVER = 4'd7,
        E_NOSOUND = 4'd8, E_PRIMARY = 4'd9, E_FMTSIZE = 4'd10,
        E_FMTFIELDS = 4'd11, E_WAVESIZE = 4'd12, E_ALIGN = 4'd13,
        E_TRAILER = 4'd14
    } t_err;

    typedef struct packed {
        t_kind       kind;
        logic [7:0]  data_byte;
        logic [3:0]  status;
        logic [15:0] fmt_code;
        logic [15:0] num_channels;
        logic [31:0] rate_hz;
        logic [31:0] avg_bytes_per_second;
        logic [15:0] frame_size;
        logic [15:0] sample_width;
        logic [31:0] loop_begin;
        logic [31:0] loop_span;
        logic [31:0] length_ms;
    } t_result;

    function automatic logic [7:0] pattern_char(input logic [4:0] idx);
        case (idx)
            5'd0: pattern_char = 8'h53;  5'd1: pattern_char = 8'h6f;
            5'd2: pattern_char = 8'h75;  5'd3: pattern_char = 8'h6e;
            5'd4: pattern_char = 8'h64;  5'd5: pattern_char = 8'h45;
            5'd6: pattern_char = 8'h66;  5'd7: pattern_char = 8'h66;
            5'd8: pattern_char = 8'h65;  5'd9: pattern_char = 8'h63;
            5'd10: pattern_char = 8'h74; 5'd11: pattern_char = 8'h52;
            5'd12: pattern_char = 8'h65; 5'd13: pattern_char = 8'h61;
            5'd14: pattern_char = 8'h64; 5'd15: pattern_char = 8'h65;
            5'd16: pattern_char = 8'h72;
            default: pattern_char = 8'h00;
        endcase
    endfunction
endpackage

// File: design/xnb_sound_stream_parser_unit.sv
// Top level of the sound asset stream parser.
`timescale 1ns / 1ps
// Results are written into the result queue when their byte is accepted; a summary
// pushed with a forwarded byte of the same request is queued behind that byte.
// Throughput: one file byte per cycle; input stalls only while the four-entry
// result queue holds more than two results, since the last byte can yield two.
// Reset (synchronous, active low) returns to the first magic byte, clears all
// parse state and empties the queue. After each last byte the parser restarts.
module xnb_sound_stream_parser_unit #(
    parameter int unsigned MAX_FILE_BYTES = xsp_pkg::MaxFileBytes,
    parameter int unsigned MAX_NAME_BYTES = xsp_pkg::MaxNameBytes
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_in_byte,
    input  logic        i_last,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [1:0]  o_kind,
    output logic [7:0]  o_data_byte,
    output logic [3:0]  o_status,
    output logic [15:0] o_fmt_code,
    output logic [15:0] o_num_channels,
    output logic [31:0] o_rate_hz,
    output logic [31:0] o_avg_bytes_per_second,
    output logic [15:0] o_frame_size,
    output logic [15:0] o_sample_width,
    output logic [31:0] o_loop_begin,
    output logic [31:0] o_loop_span,
    output logic [31:0] o_length_ms
);
    import xsp_pkg::*;

    // parse phases, header bytes are phases 0..9
    localparam logic [4:0] PH_RCOUNT = 5'd10, PH_NAMELEN = 5'd11, PH_NAME = 5'd12,
        PH_RVER = 5'd13, PH_SHARED = 5'd14, PH_PRIMARY = 5'd15, PH_FMTSIZE = 5'd16,
        PH_FMT = 5'd17, PH_WAVESIZE = 5'd18, PH_WAVE = 5'd19, PH_LOOP = 5'd20,
        PH_DONE = 5'd21, PH_ERR = 5'd22;

    logic [4:0]  r_ph, n_ph;
    logic [31:0] r_seen, n_seen;
    logic        r_sat, n_sat;
    logic [31:0] r_acc, n_acc;
    logic [2:0]  r_vsh, n_vsh;
    logic [31:0] r_rem, n_rem;
    logic [6:0]  r_rl, n_rl;
    logic [4:0]  r_mp, n_mp;
    logic        r_snd, n_snd;
    logic [31:0] r_decl, n_decl;
    logic [3:0]  r_err, n_err;
    logic [15:0] r_fbc, n_fbc;
    logic [31:0] r_fmt [6];
    logic [31:0] n_fmt [6];
    logic [31:0] r_loop [3];
    logic [31:0] n_loop [3];

    logic        accept, push0, push1;
    t_result     item0, item1;
    logic        room;
    t_result     q_out;

    // varint helpers
    logic [31:0] v_acc;
    logic        v_more, v_long;
    logic [31:0] w_acc;
    logic [31:0] w_rem;
    logic        w_done;
    logic [31:0] rem_dec;
    logic [3:0]  st;
    logic [3:0]  fin_err;
    logic [63:0] v_sh;
    logic [3:0]  fidx;
    logic [3:0]  lpos;

    assign accept  = i_valid && o_ready;
    assign o_ready = room;

    always_comb begin
        v_sh   = {57'd0, i_in_byte[6:0]} << (6'd7 * {3'd0, r_vsh});
        v_acc  = r_acc | v_sh[31:0];
        v_more = i_in_byte[7];
        v_long = v_more && (r_vsh + 3'd1 >= 3'd5);
        w_acc  = r_acc | ({24'd0, i_in_byte} << {(2'd0 - r_rem[1:0]), 3'b000});
        w_rem  = r_rem - 32'd1;
        w_done = (w_rem == 32'd0);
        rem_dec = r_rem - 32'd1;
        fidx   = r_acc[3:0];
        lpos   = 4'd12 - r_rem[3:0];
    end

    always_comb begin
        n_ph = r_ph; n_acc = r_acc; n_vsh = r_vsh; n_rem = r_rem; n_rl = r_rl;
        n_mp = r_mp; n_snd = r_snd; n_decl = r_decl; n_err = r_err; n_fbc = r_fbc;
        n_fmt = r_fmt; n_loop = r_loop;
        n_sat = r_sat; n_seen = r_seen;
        push0 = 1'b0; item0 = '0;
        if (r_seen == 32'hFFFF_FFFF) n_sat = 1'b1;
        else n_seen = r_seen + 32'd1;

        if (r_ph < 5'd10) begin
            if (r_ph < 5'd3 && i_in_byte != (r_ph == 5'd0 ? 8'h58 :
                                              r_ph == 5'd1 ? 8'h4e : 8'h42)) begin
                n_err = E_MAGIC; n_ph = PH_ERR;
            end else if (r_ph == 5'd5 && i_in_byte[7]) begin
                n_err = E_COMPRESSED; n_ph = PH_ERR;
            end else begin
                if (r_ph >= 5'd6)
                    n_decl = r_decl | ({24'd0, i_in_byte} << {r_ph[1:0] - 2'd2, 3'b000});
                n_ph = r_ph + 5'd1;
                if (r_ph == 5'd9) begin
                    n_ph = PH_RCOUNT; n_acc = '0; n_vsh = '0;
                end
            end
        end else begin
            case (r_ph)
                PH_RCOUNT, PH_NAMELEN, PH_SHARED, PH_PRIMARY: begin
                    n_acc = v_acc;
                    n_vsh = r_vsh + 3'd1;
                    if (v_long) begin
                        n_ph = PH_ERR;
                        n_err = (r_ph == PH_RCOUNT) ? E_RCOUNT :
                                (r_ph == PH_NAMELEN) ? E_RNAME : E_PRIMARY;
                    end else if (!v_more) begin
                        case (r_ph)
                            PH_RCOUNT: begin
                                if (v_acc == 32'd0 || v_acc > 32'd64) begin
                                    n_err = E_RCOUNT; n_ph = PH_ERR;
                                end else begin
                                    n_rl = v_acc[6:0];
                                    n_ph = PH_NAMELEN; n_acc = '0; n_vsh = '0;
                                end
                            end
                            PH_NAMELEN: begin
                                if (v_acc > MAX_NAME_BYTES) begin
                                    n_err = E_RNAME; n_ph = PH_ERR;
                                end else begin
                                    n_mp = '0;
                                    n_rem = v_acc;
                                    if (v_acc == 32'd0) begin
                                        n_ph = PH_RVER; n_acc = '0; n_rem = 32'd4;
                                    end else n_ph = PH_NAME;
                                end
                            end
                            PH_SHARED: begin
                                n_ph = PH_PRIMARY; n_acc = '0; n_vsh = '0;
                            end
                            default: begin
                                if (v_acc == 32'd0) begin
                                    n_err = E_PRIMARY; n_ph = PH_ERR;
                                end else begin
                                    n_ph = PH_FMTSIZE; n_acc = '0; n_rem = 32'd4;
                                end
                            end
                        endcase
                    end
                end
                PH_NAME: begin
                    if (i_in_byte == pattern_char(r_mp)) begin
                        n_mp = r_mp + 5'd1;
                        if (r_mp == 5'd16) begin
                            n_snd = 1'b1; n_mp = '0;
                        end
                    end else n_mp = (i_in_byte == 8'h53) ? 5'd1 : 5'd0;
                    n_rem = rem_dec;
                    if (rem_dec == 32'd0) begin
                        n_ph = PH_RVER; n_acc = '0; n_rem = 32'd4;
                    end
                end
                PH_RVER: begin
                    n_acc = w_acc; n_rem = w_rem;
                    if (w_done) begin
                        n_rl = r_rl - 7'd1;
                        if (r_rl == 7'd1) begin
                            if (!r_snd) begin
                                n_err = E_NOSOUND; n_ph = PH_ERR;
                            end else begin
                                n_ph = PH_SHARED; n_acc = '0; n_vsh = '0;
                            end
                        end else begin
                            n_ph = PH_NAMELEN; n_acc = '0; n_vsh = '0;
                        end
                    end
                end
                PH_FMTSIZE: begin
                    n_acc = w_acc; n_rem = w_rem;
                    if (w_done) begin
                        if (w_acc < 32'd16 || w_acc > 32'd256) begin
                            n_err = E_FMTSIZE; n_ph = PH_ERR;
                        end else begin
                            n_rem = w_acc; n_acc = '0; n_ph = PH_FMT;
                        end
                    end
                end
                PH_FMT: begin
                    if (r_acc < 32'd16) begin
                        case (fidx)
                            4'd0, 4'd1:
                                n_fmt[0] = r_fmt[0] | ({24'd0, i_in_byte} << {fidx[0], 3'b0});
                            4'd2, 4'd3:
                                n_fmt[1] = r_fmt[1] | ({24'd0, i_in_byte} << {fidx[0], 3'b0});
                            4'd4, 4'd5, 4'd6, 4'd7:
                                n_fmt[2] = r_fmt[2] | ({24'd0, i_in_byte} << {fidx[1:0], 3'b0});
                            4'd8, 4'd9, 4'd10, 4'd11:
                                n_fmt[3] = r_fmt[3] | ({24'd0, i_in_byte} << {fidx[1:0], 3'b0});
                            4'd12, 4'd13:
                                n_fmt[4] = r_fmt[4] | ({24'd0, i_in_byte} << {fidx[0], 3'b0});
                            default:
                                n_fmt[5] = r_fmt[5] | ({24'd0, i_in_byte} << {fidx[0], 3'b0});
                        endcase
                    end
                    n_acc = r_acc + 32'd1;
                    n_rem = rem_dec;
                    if (rem_dec == 32'd0) begin
                        if (n_fmt[1] == 32'd0 || n_fmt[2] == 32'd0 || n_fmt[4] == 32'd0) begin
                            n_err = E_FMTFIELDS; n_ph = PH_ERR;
                        end else begin
                            n_ph = PH_WAVESIZE; n_acc = '0; n_rem = 32'd4;
                        end
                    end
                    push0 = 1'b1; item0.kind = K_FORMAT; item0.data_byte = i_in_byte;
                end
                PH_WAVESIZE: begin
                    n_acc = w_acc; n_rem = w_rem;
                    if (w_done) begin
                        if (w_acc == 32'd0 || w_acc > MAX_FILE_BYTES) begin
                            n_err = E_WAVESIZE; n_ph = PH_ERR;
                        end else begin
                            n_rem = w_acc; n_fbc = '0; n_ph = PH_WAVE;
                        end
                    end
                end
                PH_WAVE: begin
                    n_fbc = r_fbc + 16'd1;
                    if ({16'd0, n_fbc} >= {16'd0, r_fmt[4][15:0]} || r_fbc == 16'hFFFF)
                        n_fbc = '0;
                    n_rem = rem_dec;
                    if (rem_dec == 32'd0) begin
                        if (r_fmt[0] == 32'd1 && n_fbc != 16'd0) begin
                            n_err = E_ALIGN; n_ph = PH_ERR;
                        end else begin
                            n_ph = PH_LOOP; n_rem = 32'd12;
                        end
                    end
                    push0 = 1'b1; item0.kind = K_WAVE; item0.data_byte = i_in_byte;
                end
                PH_LOOP: begin
                    if (lpos < 4'd4)
                        n_loop[0] = r_loop[0] | ({24'd0, i_in_byte} << {lpos[1:0], 3'b0});
                    else if (lpos < 4'd8)
                        n_loop[1] = r_loop[1] | ({24'd0, i_in_byte} << {lpos[1:0], 3'b0});
                    else
                        n_loop[2] = r_loop[2] | ({24'd0, i_in_byte} << {lpos[1:0], 3'b0});
                    n_rem = rem_dec;
                    if (rem_dec == 32'd0) n_ph = PH_DONE;
                end
                default: ;
            endcase
        end

        // summary on the last byte
        fin_err = n_err;
        if (n_err == E_OK) begin
            case (n_ph)
                PH_RCOUNT: fin_err = E_RCOUNT;
                PH_NAMELEN, PH_NAME: fin_err = E_RNAME;
                PH_RVER: fin_err = E_RVER;
                PH_SHARED, PH_PRIMARY: fin_err = E_PRIMARY;
                PH_FMTSIZE, PH_FMT: fin_err = E_FMTSIZE;
                PH_WAVESIZE, PH_WAVE: fin_err = E_WAVESIZE;
                PH_LOOP: fin_err = E_TRAILER;
                default: fin_err = E_OK;
            endcase
        end
        if (n_sat || n_seen < 32'd10 || n_seen > MAX_FILE_BYTES) st = E_SIZE;
        else if (fin_err == E_MAGIC || fin_err == E_COMPRESSED) st = fin_err;
        else if (n_decl != n_seen) st = E_DECLARED;
        else st = fin_err;
        item1 = '0;
        item1.kind = K_SUMMARY;
        item1.status = st;
        if (st == E_OK) begin
            item1.fmt_code = n_fmt[0][15:0];
            item1.num_channels = n_fmt[1][15:0];
            item1.rate_hz = n_fmt[2];
            item1.avg_bytes_per_second = n_fmt[3];
            item1.frame_size = n_fmt[4][15:0];
            item1.sample_width = n_fmt[5][15:0];
            item1.loop_begin = n_loop[0];
            item1.loop_span = n_loop[1];
            item1.length_ms = n_loop[2];
        end
        push1 = i_last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (accept && i_last)) begin
            r_ph <= '0; r_seen <= '0; r_sat <= 1'b0; r_acc <= '0; r_vsh <= '0;
            r_rem <= '0; r_rl <= '0; r_mp <= '0; r_snd <= 1'b0; r_decl <= '0;
            r_err <= '0; r_fbc <= '0;
            for (int k = 0; k < 6; k++) r_fmt[k] <= '0;
            for (int k = 0; k < 3; k++) r_loop[k] <= '0;
        end else if (accept) begin
            r_ph <= n_ph; r_seen <= n_seen; r_sat <= n_sat; r_acc <= n_acc;
            r_vsh <= n_vsh; r_rem <= n_rem; r_rl <= n_rl; r_mp <= n_mp;
            r_snd <= n_snd; r_decl <= n_decl; r_err <= n_err; r_fbc <= n_fbc;
            r_fmt <= n_fmt; r_loop <= n_loop;
        end
    end

    xsp_out_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push0 (accept && push0),
        .i_item0 (item0),
        .i_push1 (accept && push1),
        .i_item1 (item1),
        .o_room  (room),
        .o_valid (o_valid),
        .o_item  (q_out),
        .i_ready (i_ready)
    );

    assign o_kind                 = q_out.kind;
    assign o_data_byte            = q_out.data_byte;
    assign o_status               = q_out.status;
    assign o_fmt_code             = q_out.fmt_code;
    assign o_num_channels         = q_out.num_channels;
    assign o_rate_hz              = q_out.rate_hz;
    assign o_avg_bytes_per_second = q_out.avg_bytes_per_second;
    assign o_frame_size           = q_out.frame_size;
    assign o_sample_width         = q_out.sample_width;
    assign o_loop_begin           = q_out.loop_begin;
    assign o_loop_span            = q_out.loop_span;
    assign o_length_ms            = q_out.length_ms;
endmodule

// File: design/xsp_out_queue.sv
// Four-entry result queue between the parser and the output channel.
`timescale 1ns / 1ps
module xsp_out_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push0,
    input  xsp_pkg::t_result i_item0,
    input  logic             i_push1,
    input  xsp_pkg::t_result i_item1,
    output logic             o_room,
    output logic             o_valid,
    output xsp_pkg::t_result o_item,
    input  logic             i_ready
);
    import xsp_pkg::*;

    t_result     r_q [4];
    logic [1:0]  r_rd, r_wr;
    logic [2:0]  r_cnt;
    logic        pop;
    logic [1:0]  npush;

    assign pop     = o_valid && i_ready;
    assign o_valid = (r_cnt != 3'd0);
    assign o_item  = r_q[r_rd];
    // an accepted byte may push two results; keep two slots free
    assign o_room  = (r_cnt <= 3'd2);
    assign npush   = {1'b0, i_push0} + {1'b0, i_push1};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd  <= '0;
            r_wr  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push0) r_q[r_wr] <= i_item0;
            if (i_push1) r_q[i_push0 ? r_wr + 2'd1 : r_wr] <= i_item1;
            r_wr  <= r_wr + npush;
            if (pop) r_rd <= r_rd + 2'd1;
            r_cnt <= r_cnt + {1'b0, npush} - {2'b0, pop};
        end
    end
endmodule
